// ----- hw/rtl/tz_lts_pkg.sv -----
// ----------------------------------------------------------------------------
// Line token scanner package
// Event and phase codes, event-group codes, character constants and
// the helpers used by the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tz_lts_pkg;

  localparam int CharW = 8;
  localparam int LineW = 20;
  localparam int ColW  = 16;
  localparam int EvW   = 3;
  localparam int PatW  = 4;
  localparam int IdxW  = 3;
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;
  localparam int QCntW  = 3;

  localparam logic [LineW-1:0] LineMax = {LineW{1'b1}};
  localparam logic [ColW-1:0]  ColMax  = {ColW{1'b1}};

  // Scan phases
  localparam logic [1:0] PhFirst = 2'd0;
  localparam logic [1:0] PhToken = 2'd1;
  localparam logic [1:0] PhGap   = 2'd2;
  localparam logic [1:0] PhSkip  = 2'd3;

  // Event codes
  localparam logic [EvW-1:0] EvRoot  = 3'd0;
  localparam logic [EvW-1:0] EvChild = 3'd1;
  localparam logic [EvW-1:0] EvChar  = 3'd2;
  localparam logic [EvW-1:0] EvEnd   = 3'd3;
  localparam logic [EvW-1:0] EvClose = 3'd4;
  localparam logic [EvW-1:0] EvError = 3'd5;

  // Event groups caused by one item
  localparam logic [PatW-1:0] PatNone     = 4'd0;
  localparam logic [PatW-1:0] PatRoot     = 4'd1;
  localparam logic [PatW-1:0] PatTab      = 4'd2;
  localparam logic [PatW-1:0] PatErr      = 4'd3;
  localparam logic [PatW-1:0] PatEnd      = 4'd4;
  localparam logic [PatW-1:0] PatEndClose = 4'd5;
  localparam logic [PatW-1:0] PatErrChar  = 4'd6;
  localparam logic [PatW-1:0] PatChar     = 4'd7;
  localparam logic [PatW-1:0] PatClose    = 4'd8;

  // Characters
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChLf    = 8'h0A;
  localparam logic [CharW-1:0] ChVt    = 8'h0B;
  localparam logic [CharW-1:0] ChFf    = 8'h0C;
  localparam logic [CharW-1:0] ChCr    = 8'h0D;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChHash  = 8'h23;
  localparam logic [CharW-1:0] ChPct   = 8'h25;
  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChSlash = 8'h2F;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChColon = 8'h3A;
  localparam logic [CharW-1:0] ChLt    = 8'h3C;
  localparam logic [CharW-1:0] ChEq    = 8'h3D;
  localparam logic [CharW-1:0] ChGt    = 8'h3E;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpL   = 8'h4C;
  localparam logic [CharW-1:0] ChUpR   = 8'h52;
  localparam logic [CharW-1:0] ChUpZ   = 8'h5A;
  localparam logic [CharW-1:0] ChUscr  = 8'h5F;
  localparam logic [CharW-1:0] ChLoA   = 8'h61;
  localparam logic [CharW-1:0] ChLoZ   = 8'h7A;

  typedef struct packed {
    logic [PatW-1:0]  pat;
    logic [CharW-1:0] ch;
    logic [LineW-1:0] line;
    logic [ColW-1:0]  col;
  } cmd_t;

  function automatic logic is_white(input logic [CharW-1:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChVt) ||
           (c == ChFf) || (c == ChCr);
  endfunction

  function automatic logic is_token_byte(input logic [CharW-1:0] c);
    logic alnum;
    alnum = ((c >= ChUpA) && (c <= ChUpZ)) || ((c >= ChLoA) && (c <= ChLoZ)) ||
            ((c >= ChZero) && (c <= ChNine));
    return alnum || (c == ChPlus) || (c == ChMinus) || (c == ChUscr) ||
           (c == ChLt) || (c == ChGt) || (c == ChEq) || (c == ChColon) ||
           (c == ChSlash) || (c == ChPct);
  endfunction

  function automatic logic [IdxW-1:0] pat_len(input logic [PatW-1:0] p);
    logic [IdxW-1:0] n;
    case (p)
      PatRoot:     n = 3'd2;
      PatTab:      n = 3'd5;
      PatErr:      n = 3'd1;
      PatEnd:      n = 3'd1;
      PatEndClose: n = 3'd2;
      PatErrChar:  n = 3'd2;
      PatChar:     n = 3'd1;
      PatClose:    n = 3'd1;
      default:     n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [EvW-1:0] pat_event(input logic [PatW-1:0] p,
                                               input logic [IdxW-1:0] i);
    logic [EvW-1:0] e;
    case (p)
      PatRoot:     e = (i == 3'd0) ? EvRoot : EvChar;
      PatTab: begin
        case (i)
          3'd0:    e = EvChild;
          3'd1:    e = EvChar;
          3'd2:    e = EvEnd;
          3'd3:    e = EvChar;
          default: e = EvEnd;
        endcase
      end
      PatErr:      e = EvError;
      PatEnd:      e = EvEnd;
      PatEndClose: e = (i == 3'd0) ? EvEnd : EvClose;
      PatErrChar:  e = (i == 3'd0) ? EvError : EvChar;
      PatChar:     e = EvChar;
      PatClose:    e = EvClose;
      default:     e = EvClose;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tz_lts_if.sv -----
// ----------------------------------------------------------------------------
// Line token scanner channels
// Valid/ready channels for input bytes and for scan events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tz_lts_in_if import tz_lts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface

interface tz_lts_out_if import tz_lts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [EvW-1:0]   event_res;
  logic [CharW-1:0] char_value;
  logic [LineW-1:0] line_number;
  logic [ColW-1:0]  column_number;
  logic             last;

  modport source (output valid, output event_res, output char_value,
                  output line_number, output column_number, output last,
                  input ready);
  modport sink (input valid, input event_res, input char_value,
                input line_number, input column_number, input last,
                output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tz_line_token_scanner_core.sv -----
// ----------------------------------------------------------------------------
// Line token scanner core
// Scans a byte stream line by line and emits element, token and error events.
// ----------------------------------------------------------------------------
// The block takes one input beat per cycle as long as its four-entry command
// queue has room, and delivers one event beat per cycle while the event port
// is ready. Each input beat causes zero to five events (a tab-led line causes
// five, most bytes one or none), so sustained throughput is set by the event
// port, and short bursts of heavy lines are absorbed by the queue. An accepted
// byte's command passes through the queue and the output register before its
// first event appears. An end-of-input beat closes the open element and
// returns all scanner state to its reset values.
`timescale 1ns / 1ps
`default_nettype none

module tz_line_token_scanner_core import tz_lts_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  tz_lts_in_if.sink    items,
  tz_lts_out_if.source events
);

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  tz_lts_front u_front (
    .clk    (clk),
    .rst    (rst),
    .items  (items),
    .q_full (q_full),
    .push   (push),
    .cmd    (push_cmd)
  );

  tz_lts_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  tz_lts_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .events     (events)
  );

  a_eoi_pushes: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready && items.end_of_input) |-> push)
    else $error("end of input beat produced no close command");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    items.ready |-> !q_full)
    else $error("input ready while command queue full");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("command popped from empty queue");

  a_child_not_last: assert property (@(posedge clk) disable iff (rst)
    (events.valid && ((events.event_res == EvChild) || (events.event_res == EvRoot)))
      |-> !events.last)
    else $error("open element marked as final event of its beat");

endmodule

`default_nettype wire

// ----- hw/rtl/tz_lts_front.sv -----
// ----------------------------------------------------------------------------
// Line token scanner front
// Accepts one beat per cycle while the command queue has room, runs the line
// scanner state and pushes one event-group command per beat that causes events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tz_lts_front import tz_lts_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  tz_lts_in_if.sink   items,
  input  wire logic   q_full,
  output logic        push,
  output cmd_t        cmd
);

  logic [1:0]       phase, phase_next;
  logic [CharW-1:0] first_byte, first_byte_next;
  logic [LineW-1:0] line_cnt, line_cnt_next;
  logic [ColW-1:0]  col_cnt, col_cnt_next;
  logic [PatW-1:0]  pat;
  logic [CharW-1:0] c;
  logic             accept;
  logic             sep;
  logic             not_z;

  assign items.ready = !q_full;
  assign accept      = items.valid && items.ready;
  assign c           = items.char_code;
  assign sep         = (c == ChSpace) || (c == ChTab) || (c == ChLf);
  assign not_z       = (first_byte != ChUpZ);

  always_comb begin
    pat             = PatNone;
    phase_next      = phase;
    first_byte_next = first_byte;
    line_cnt_next   = line_cnt;
    col_cnt_next    = (col_cnt < ColMax) ? col_cnt + 1'b1 : col_cnt;
    if (items.end_of_input) begin
      pat             = (phase == PhToken) ? PatEndClose : PatClose;
      phase_next      = PhFirst;
      first_byte_next = '0;
      line_cnt_next   = '0;
      col_cnt_next    = '0;
    end else begin
      case (phase)
        PhFirst: begin
          line_cnt_next   = (line_cnt < LineMax) ? line_cnt + 1'b1 : line_cnt;
          col_cnt_next    = '0;
          first_byte_next = c;
          if ((c == ChUpR) || (c == ChUpZ) || (c == ChUpL)) begin
            pat        = PatRoot;
            phase_next = PhToken;
          end else if (c == ChTab) begin
            pat        = PatTab;
            phase_next = PhGap;
          end else if (c == ChLf) begin
            pat = PatNone;
          end else if ((c == ChHash) || is_white(c)) begin
            phase_next = PhSkip;
          end else begin
            pat = PatErr;
          end
        end
        PhToken: begin
          if (sep) begin
            if (c == ChLf) begin
              phase_next = PhFirst;
              pat        = not_z ? PatEndClose : PatEnd;
            end else begin
              phase_next = PhGap;
              pat        = PatEnd;
            end
          end else begin
            pat = is_token_byte(c) ? PatChar : PatErrChar;
          end
        end
        PhGap: begin
          if (c == ChHash) begin
            phase_next = PhSkip;
            pat        = not_z ? PatClose : PatNone;
          end else if (!sep) begin
            phase_next = PhToken;
            pat        = PatChar;
          end
        end
        default: begin
          if (c == ChLf) begin
            phase_next = PhFirst;
          end
        end
      endcase
    end
  end

  // Events carry the counters after this beat's update; end of input
  // reports the counters it found.
  always_comb begin
    cmd.pat  = pat;
    cmd.ch   = c;
    cmd.line = items.end_of_input ? line_cnt : line_cnt_next;
    cmd.col  = items.end_of_input ? col_cnt : col_cnt_next;
  end

  assign push = accept && (pat != PatNone);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PhFirst;
      first_byte <= '0;
      line_cnt   <= '0;
      col_cnt    <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      first_byte <= first_byte_next;
      line_cnt   <= line_cnt_next;
      col_cnt    <= col_cnt_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tz_lts_queue.sv -----
// ----------------------------------------------------------------------------
// Line token scanner command queue
// Four-entry first-in first-out queue of event-group commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tz_lts_queue import tz_lts_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head_cmd
);

  cmd_t             mem [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == QCntW'(QDepth));
  assign head_valid = (count != '0);
  assign head_cmd   = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tz_lts_back.sv -----
// ----------------------------------------------------------------------------
// Line token scanner back
// Expands each event-group command into its events, one beat per cycle while
// the event port is ready, through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tz_lts_back import tz_lts_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   head_valid,
  input  wire cmd_t   head_cmd,
  output logic        pop,
  tz_lts_out_if.source events
);

  logic [IdxW-1:0] idx;
  logic            load;
  logic            take;
  logic            at_last;
  logic [EvW-1:0]  ev;

  assign load    = !events.valid || events.ready;
  assign take    = load && head_valid;
  assign at_last = (idx == pat_len(head_cmd.pat) - 1'b1);
  assign pop     = take && at_last;
  assign ev      = pat_event(head_cmd.pat, idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      events.valid <= 1'b0;
      idx          <= '0;
    end else if (load) begin
      events.valid <= head_valid;
      if (head_valid) begin
        idx <= at_last ? '0 : idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      events.event_res     <= ev;
      events.char_value    <= ((ev == EvChar) || (ev == EvError)) ? head_cmd.ch : '0;
      events.line_number   <= head_cmd.line;
      events.column_number <= head_cmd.col;
      events.last          <= at_last;
    end
  end

endmodule

`default_nettype wire

// ----- bench/tz_line_token_scanner_core_tb.sv -----
// ----------------------------------------------------------------------------
// Line token scanner core testbench
// Streams directed and random text through the scanner with random gaps on
// both channels and one long output stall. A scoreboard class keeps its own
// copy of the scan phase, first byte, and line and column counters. It
// predicts each event and checks every event beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tz_line_token_scanner_core_tb;
  import tz_lts_pkg::*;

  localparam int CycleLimit  = 1_000_000;
  localparam int RandomBeats = 144;
  localparam int HoldCycles  = 150;
  localparam int DrainCycles = 20;

  typedef struct {
    logic [EvW-1:0]   ev;
    logic [CharW-1:0] ch;
    logic [LineW-1:0] line;
    logic [ColW-1:0]  col;
    logic             last;
  } scan_event_t;

  class scan_scoreboard;
    logic [1:0]       phase;
    logic [CharW-1:0] first_byte;
    logic [LineW-1:0] line_cnt;
    logic [ColW-1:0]  col_cnt;
    scan_event_t      expected_events[$];
    int               errors;
    int               checked;

    function new();
      errors = 0;
      checked = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      phase = PhFirst;
      first_byte = '0;
      line_cnt = '0;
      col_cnt = '0;
    endfunction

    function bit spacing_byte(input logic [CharW-1:0] c);
      return c == ChSpace || c == ChTab || c == ChLf || c == ChVt ||
             c == ChFf || c == ChCr;
    endfunction

    function bit token_char_ok(input logic [CharW-1:0] c);
      if ((c >= ChUpA && c <= ChUpZ) || (c >= ChLoA && c <= ChLoZ) ||
          (c >= ChZero && c <= ChNine))
        return 1'b1;
      return c == ChPlus || c == ChMinus || c == ChUscr || c == ChLt ||
             c == ChGt || c == ChEq || c == ChColon || c == ChSlash || c == ChPct;
    endfunction

    function void add_event(input logic [EvW-1:0] ev, input logic [CharW-1:0] ch);
      scan_event_t e;
      e.ev = ev;
      e.ch = ch;
      e.line = line_cnt;
      e.col = col_cnt;
      e.last = 1'b0;
      expected_events.push_back(e);
    endfunction

    function void note_byte(input logic [CharW-1:0] c, input logic eoi);
      int base;
      base = expected_events.size();
      if (eoi) begin
        if (phase == PhToken) add_event(EvEnd, '0);
        add_event(EvClose, '0);
        clear_scan();
      end else begin
        if (col_cnt != ColMax) col_cnt++;
        case (phase)
          PhFirst: begin
            if (line_cnt != LineMax) line_cnt++;
            col_cnt = '0;
            first_byte = c;
            if (c == ChUpR || c == ChUpZ || c == ChUpL) begin
              add_event(EvRoot, '0);
              add_event(EvChar, c);
              phase = PhToken;
            end else if (c == ChTab) begin
              add_event(EvChild, '0);
              add_event(EvChar, c);
              add_event(EvEnd, '0);
              add_event(EvChar, c);
              add_event(EvEnd, '0);
              phase = PhGap;
            end else if (c == ChLf) begin
              // hold phase on an empty line
            end else if (c == ChHash || spacing_byte(c)) begin
              phase = PhSkip;
            end else begin
              add_event(EvError, c);
            end
          end
          PhToken: begin
            if (c == ChSpace || c == ChTab || c == ChLf) begin
              add_event(EvEnd, '0);
              if (c == ChLf) begin
                phase = PhFirst;
                if (first_byte != ChUpZ) add_event(EvClose, '0);
              end else begin
                phase = PhGap;
              end
            end else begin
              if (!token_char_ok(c)) add_event(EvError, c);
              add_event(EvChar, c);
            end
          end
          PhGap: begin
            if (c == ChHash) begin
              phase = PhSkip;
              if (first_byte != ChUpZ) add_event(EvClose, '0);
            end else if (c != ChSpace && c != ChTab && c != ChLf) begin
              add_event(EvChar, c);
              phase = PhToken;
            end
          end
          default: begin
            if (c == ChLf) phase = PhFirst;
          end
        endcase
      end
      if (expected_events.size() > base)
        expected_events[expected_events.size() - 1].last = 1'b1;
    endfunction

    function void check_event(input logic [EvW-1:0] ev, input logic [CharW-1:0] ch,
                              input logic [LineW-1:0] line, input logic [ColW-1:0] col,
                              input logic last);
      scan_event_t e;
      checked++;
      if (expected_events.size() == 0) begin
        $error("unexpected event beat: event_res %0d char_value %0d", ev, ch);
        errors++;
        return;
      end
      e = expected_events.pop_front();
      if (ev !== e.ev) begin
        $error("event_res: expected %0d, actual %0d", e.ev, ev);
        errors++;
      end
      if (ch !== e.ch) begin
        $error("char_value: expected %0d, actual %0d", e.ch, ch);
        errors++;
      end
      if (line !== e.line) begin
        $error("line_number: expected %0d, actual %0d", e.line, line);
        errors++;
      end
      if (col !== e.col) begin
        $error("column_number: expected %0d, actual %0d", e.col, col);
        errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %0d, actual %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  tz_lts_in_if  items_if ();
  tz_lts_out_if events_if ();

  tz_line_token_scanner_core DUT (
    .clk    (clk),
    .rst    (rst),
    .items  (items_if),
    .events (events_if)
  );

  scan_scoreboard sb;
  int beats_sent   = 0;
  bit sender_calm  = 1'b0;
  bit hold_request = 1'b0;
  bit hold_done    = 1'b0;
  int cycles       = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic send_beat(input logic [CharW-1:0] c, input logic eoi);
    @(negedge clk);
    while (!sender_calm && $urandom_range(0, 99) < 22) begin
      items_if.valid <= 1'b0;
      @(negedge clk);
    end
    items_if.valid        <= 1'b1;
    items_if.char_code    <= c;
    items_if.end_of_input <= eoi;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    sb.note_byte(c, eoi);
    beats_sent++;
  endtask

  function automatic logic [CharW-1:0] pick_token_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'($urandom_range(0, 255));
    if (r < 28) return 8'($urandom_range(ChUpA, ChUpZ));
    if (r < 48) return 8'($urandom_range(ChLoA, ChLoZ));
    if (r < 70) return 8'($urandom_range(ChZero, ChNine));
    case ($urandom_range(0, 8))
      0: return ChPlus;
      1: return ChMinus;
      2: return ChUscr;
      3: return ChLt;
      4: return ChGt;
      5: return ChEq;
      6: return ChColon;
      7: return ChSlash;
      default: return ChPct;
    endcase
  endfunction

  task automatic send_tokens();
    int ntok;
    int len;
    ntok = $urandom_range(0, 3);
    for (int t = 0; t < ntok; t++) begin
      repeat ($urandom_range(1, 2)) send_beat($urandom_range(0, 1) ? ChSpace : ChTab, 1'b0);
      len = $urandom_range(1, 4);
      repeat (len) send_beat(pick_token_char(), 1'b0);
    end
    if ($urandom_range(0, 4) == 0) begin
      send_beat(ChSpace, 1'b0);
      send_beat(ChHash, 1'b0);
      repeat ($urandom_range(0, 3)) send_beat(pick_token_char(), 1'b0);
    end
    if ($urandom_range(0, 9) == 0) send_beat(8'($urandom), 1'b1);
    else send_beat(ChLf, 1'b0);
  endtask

  task automatic send_line();
    int r;
    r = $urandom_range(0, 99);
    if (r < 32) begin
      case ($urandom_range(0, 2))
        0: send_beat(ChUpR, 1'b0);
        1: send_beat(ChUpZ, 1'b0);
        default: send_beat(ChUpL, 1'b0);
      endcase
      repeat ($urandom_range(0, 3)) send_beat(pick_token_char(), 1'b0);
      send_tokens();
    end else if (r < 50) begin
      send_beat(ChTab, 1'b0);
      if ($urandom_range(0, 1)) repeat ($urandom_range(1, 3)) send_beat(pick_token_char(), 1'b0);
      send_tokens();
    end else if (r < 60) begin
      send_beat($urandom_range(0, 1) ? ChHash : ChSpace, 1'b0);
      repeat ($urandom_range(0, 3)) send_beat(8'($urandom_range(0, 255)), 1'b0);
      send_beat(ChLf, 1'b0);
    end else if (r < 67) begin
      send_beat(ChLf, 1'b0);
    end else if (r < 75) begin
      send_beat(8'($urandom), 1'b1);
    end else begin
      repeat ($urandom_range(1, 4)) send_beat(8'($urandom_range(0, 255)), 1'b0);
      if ($urandom_range(0, 2) == 0) send_beat(8'($urandom), 1'b1);
    end
  endtask

  initial begin
    int h;
    events_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        for (h = 0; h < HoldCycles; h++) begin
          events_if.ready <= 1'b0;
          @(negedge clk);
        end
      end else begin
        if (sb.checked >= 120 && sb.checked < 260) events_if.ready <= 1'b1;
        else events_if.ready <= ($urandom_range(0, 99) >= 22);
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && events_if.valid && events_if.ready)
      sb.check_event(events_if.event_res, events_if.char_value, events_if.line_number,
                     events_if.column_number, events_if.last);
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("tz_line_token_scanner_core_tb: FAIL");
    $finish;
  end

  initial begin
    int start;
    sb = new();
    items_if.valid        = 1'b0;
    items_if.char_code    = '0;
    items_if.end_of_input = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // root line, high byte inside a token, token end and close
    send_beat(ChUpR, 1'b0);
    send_beat(ChLoA, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(ChSpace, 1'b0);
    send_beat(8'h62, 1'b0);
    send_beat(ChLf, 1'b0);
    // tab-led line with a comment
    send_beat(ChTab, 1'b0);
    send_beat(8'h78, 1'b0);
    send_beat(ChHash, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(ChLf, 1'b0);
    // Z lines stay open at line feed and at comment
    send_beat(ChUpZ, 1'b0);
    send_beat(8'h71, 1'b0);
    send_beat(ChLf, 1'b0);
    send_beat(ChUpZ, 1'b0);
    send_beat(ChSpace, 1'b0);
    send_beat(ChHash, 1'b0);
    send_beat(ChLf, 1'b0);
    // bad first bytes, white first byte
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(ChCr, 1'b0);
    send_beat(ChLf, 1'b0);
    // end of input inside a token, then between lines
    send_beat(ChUpL, 1'b0);
    send_beat(ChPct, 1'b0);
    send_beat(8'hFF, 1'b1);
    send_beat(8'h00, 1'b1);

    hold_request = 1'b1;
    start = beats_sent;
    while (beats_sent - start < RandomBeats) begin
      sender_calm = (beats_sent - start >= 50) && (beats_sent - start < 100);
      send_line();
    end
    sender_calm = 1'b0;
    @(negedge clk);
    items_if.valid <= 1'b0;

    while (sb.expected_events.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) $display("tz_line_token_scanner_core_tb: PASS");
    else $display("tz_line_token_scanner_core_tb: FAIL");
    $finish;
  end

endmodule
